### src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by the cell, the handle allocator, the top level and the checker.
// No dependencies.
package spq_pkg;

   // Handles are four bits wide on both channels.
   localparam int HANDLE_BITS = 4;
   localparam int HANDLE_NUM  = 1 << HANDLE_BITS;
   localparam int ACTION_BITS = 2;
   localparam int STATUS_BITS = 2;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PUSH_AHEAD  = 2'd0,
      ACT_PUSH_BEHIND = 2'd1,
      ACT_REMOVE      = 2'd2,
      ACT_NONE        = 2'd3
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE       = 2'd0,
      ST_ZERO_PRIO  = 2'd1,
      ST_FULL       = 2'd2,
      ST_BAD_HANDLE = 2'd3
   } status_type;

   // What a cell does with its slot in one cycle.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_FROM_LEFT,
      OP_FROM_RIGHT
   } cell_op_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic                   push;
      logic                   pop;
      logic                   behind;
      logic [HANDLE_BITS-1:0] handle;
   } cell_ctrl_type;

endpackage

### src/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
   parameter int PRIO_BITS = 16,
   parameter int DATA_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [PRIO_BITS-1:0]   new_prio,
   input  logic [DATA_BITS-1:0]   new_payload,
   input  logic [HANDLE_BITS-1:0] new_handle,
   input  logic                   left_valid,
   input  logic [PRIO_BITS-1:0]   left_prio,
   input  logic [DATA_BITS-1:0]   left_payload,
   input  logic [HANDLE_BITS-1:0] left_handle,
   input  logic                   right_valid,
   input  logic [PRIO_BITS-1:0]   right_prio,
   input  logic [DATA_BITS-1:0]   right_payload,
   input  logic [HANDLE_BITS-1:0] right_handle,
   input  logic                   ge_left,
   input  logic                   hit_left,
   output logic                   ge,
   output logic                   hit,
   output logic                   valid,
   output logic [PRIO_BITS-1:0]   prio,
   output logic [DATA_BITS-1:0]   payload,
   output logic [HANDLE_BITS-1:0] handle
);

   logic                   valid_ff, valid_in;
   logic [PRIO_BITS-1:0]   prio_ff, prio_in;
   logic [DATA_BITS-1:0]   payload_ff, payload_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   cell_op_type            op;
   logic                   goes_here;

   // The new entry belongs at or before this slot when the slot is empty or
   // holds a larger priority (or an equal one for a push ahead of equals).
   assign goes_here = ctrl.behind ? (new_prio < prio_ff) : (new_prio <= prio_ff);
   assign ge  = !valid_ff || goes_here;
   assign hit = hit_left || (valid_ff && (handle_ff == ctrl.handle));

   always_comb begin
      op = OP_HOLD;
      if (ctrl.push && ge) begin
         op = ge_left ? OP_FROM_LEFT : OP_LOAD;
      end else if (ctrl.pop && hit) begin
         op = OP_FROM_RIGHT;
      end
   end

   always_comb begin
      unique case (op)
         OP_LOAD: begin
            valid_in   = 1'b1;
            prio_in    = new_prio;
            payload_in = new_payload;
            handle_in  = new_handle;
         end
         OP_FROM_LEFT: begin
            valid_in   = left_valid;
            prio_in    = left_prio;
            payload_in = left_payload;
            handle_in  = left_handle;
         end
         OP_FROM_RIGHT: begin
            valid_in   = right_valid;
            prio_in    = right_prio;
            payload_in = right_payload;
            handle_in  = right_handle;
         end
         default: begin
            valid_in   = valid_ff;
            prio_in    = prio_ff;
            payload_in = payload_ff;
            handle_in  = handle_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         prio_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         prio_ff  <= prio_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      handle_ff  <= handle_in;
   end

   assign valid   = valid_ff;
   assign prio    = prio_ff;
   assign payload = payload_ff;
   assign handle  = handle_ff;

endmodule

### src/spq_handle_alloc.sv
// Handle bookkeeping: in-use flags and the lowest free handle.
// Depends on spq_pkg.
module spq_handle_alloc import spq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic                   give_back,
   input  logic [HANDLE_BITS-1:0] give_back_handle,
   output logic [HANDLE_NUM-1:0]  in_use,
   output logic                   free_found,
   output logic [HANDLE_BITS-1:0] free_handle
);

   logic [HANDLE_NUM-1:0] in_use_ff, in_use_in;

   always_comb begin
      free_found  = 1'b0;
      free_handle = '0;
      for (int h = HANDLE_NUM - 1; h >= 0; h--) begin
         if (h < DEPTH && !in_use_ff[h]) begin
            free_found  = 1'b1;
            free_handle = HANDLE_BITS'(h);
         end
      end
   end

   always_comb begin
      in_use_in = in_use_ff;
      if (take) begin
         in_use_in[free_handle] = 1'b1;
      end
      if (give_back) begin
         in_use_in[give_back_handle] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   assign in_use = in_use_ff;

endmodule

### src/sorted_priority_queue.sv
// Sorted priority queue: a chain of DEPTH cells kept in ascending priority
// from cell 0. Every action (push ahead of equals, push behind equals, remove
// by handle) is applied to all cells at once, so one word is taken per
// clock; its response word is shown the cycle after and is held in an output
// register, which lets a new word in whenever that register is empty or being
// read. Depends on spq_pkg, spq_cell and spq_handle_alloc.
module sorted_priority_queue import spq_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int PRIO_BITS = 16,
   parameter int DATA_BITS = 32,
   localparam int CNT_BITS = $clog2(DEPTH + 1),
   localparam int REQ_RAW  = PRIO_BITS + DATA_BITS + HANDLE_BITS,
   localparam int REQ_BITS = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW  = STATUS_BITS + HANDLE_BITS + CNT_BITS + 1 + PRIO_BITS + DATA_BITS,
   localparam int RSP_BITS = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // From bit 0: priority_req, payload, handle_in, zero fill.
   input  logic [REQ_BITS-1:0]    req_tdata,
   // Bits: action.
   input  logic [ACTION_BITS-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // From bit 0: status, handle_out, count, head_valid, head_priority,
   // head_payload, zero fill.
   output logic [RSP_BITS-1:0]    rsp_tdata
);

   logic [PRIO_BITS-1:0]   req_prio;
   logic [DATA_BITS-1:0]   req_payload;
   logic [HANDLE_BITS-1:0] req_handle;
   action_type             req_action;
   logic                   accept, is_push, is_remove;
   status_type             status;
   cell_ctrl_type          ctrl;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;

   logic [HANDLE_NUM-1:0]  in_use;
   logic                   free_found;
   logic [HANDLE_BITS-1:0] free_handle;

   logic                   cell_valid   [DEPTH];
   logic [PRIO_BITS-1:0]   cell_prio    [DEPTH];
   logic [DATA_BITS-1:0]   cell_payload [DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle  [DEPTH];
   logic                   cell_ge      [DEPTH];
   logic                   cell_hit     [DEPTH];

   assign req_prio    = req_tdata[PRIO_BITS-1:0];
   assign req_payload = req_tdata[PRIO_BITS +: DATA_BITS];
   assign req_handle  = req_tdata[PRIO_BITS + DATA_BITS +: HANDLE_BITS];
   assign req_action  = action_type'(req_tuser);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_push    = (req_action == ACT_PUSH_AHEAD) || (req_action == ACT_PUSH_BEHIND);
   assign is_remove  = (req_action == ACT_REMOVE);

   always_comb begin
      priority if (is_push && (req_prio == '0)) begin
         status = ST_ZERO_PRIO;
      end else if (is_push && ((count_ff == CNT_BITS'(DEPTH)) || !free_found)) begin
         status = ST_FULL;
      end else if (is_remove && !in_use[req_handle]) begin
         status = ST_BAD_HANDLE;
      end else begin
         status = ST_DONE;
      end
   end

   assign ctrl.push   = accept && is_push && (status == ST_DONE);
   assign ctrl.pop    = accept && is_remove && (status == ST_DONE);
   assign ctrl.behind = (req_action == ACT_PUSH_BEHIND);
   assign ctrl.handle = req_handle;

   spq_handle_alloc #(
      .DEPTH(DEPTH)
   ) u_alloc (
      .clock            (clock),
      .reset            (reset),
      .take             (ctrl.push),
      .give_back        (ctrl.pop),
      .give_back_handle (req_handle),
      .in_use           (in_use),
      .free_found       (free_found),
      .free_handle      (free_handle)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                   lv, rv, gl, hl;
      logic [PRIO_BITS-1:0]   lp, rp;
      logic [DATA_BITS-1:0]   ld, rd;
      logic [HANDLE_BITS-1:0] lh, rh;

      if (i == 0) begin : g_first
         assign lv = 1'b0;
         assign lp = '0;
         assign ld = '0;
         assign lh = '0;
         assign gl = 1'b0;
         assign hl = 1'b0;
      end else begin : g_inner_left
         assign lv = cell_valid[i-1];
         assign lp = cell_prio[i-1];
         assign ld = cell_payload[i-1];
         assign lh = cell_handle[i-1];
         assign gl = cell_ge[i-1];
         assign hl = cell_hit[i-1];
      end

      // The last cell is refilled with an empty slot when entries move up.
      if (i == DEPTH - 1) begin : g_last
         assign rv = 1'b0;
         assign rp = '0;
         assign rd = '0;
         assign rh = '0;
      end else begin : g_inner_right
         assign rv = cell_valid[i+1];
         assign rp = cell_prio[i+1];
         assign rd = cell_payload[i+1];
         assign rh = cell_handle[i+1];
      end

      spq_cell #(
         .PRIO_BITS(PRIO_BITS),
         .DATA_BITS(DATA_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .new_prio      (req_prio),
         .new_payload   (req_payload),
         .new_handle    (free_handle),
         .left_valid    (lv),
         .left_prio     (lp),
         .left_payload  (ld),
         .left_handle   (lh),
         .right_valid   (rv),
         .right_prio    (rp),
         .right_payload (rd),
         .right_handle  (rh),
         .ge_left       (gl),
         .hit_left      (hl),
         .ge            (cell_ge[i]),
         .hit           (cell_hit[i]),
         .valid         (cell_valid[i]),
         .prio          (cell_prio[i]),
         .payload       (cell_payload[i]),
         .handle        (cell_handle[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      handle_in    = handle_ff;
      count_in     = count_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = status;
         handle_in    = ctrl.push ? free_handle : '0;
      end
      if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         status_ff    <= ST_DONE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
   end

   // The head cell only changes when a word is accepted, which also loads the
   // response register, so it always matches the response on display.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({
      cell_valid[0] ? cell_payload[0] : {DATA_BITS{1'b0}},
      cell_valid[0] ? cell_prio[0] : {PRIO_BITS{1'b0}},
      cell_valid[0],
      count_ff,
      handle_ff,
      status_ff
   });

endmodule

### src/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to its top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker import spq_pkg::*; #(
   parameter int DEPTH    = 16,
   parameter int CNT_BITS = 5,
   parameter int RSP_BITS = 64
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_BITS-1:0]    rsp_tdata
);

   localparam int CNT_LO = STATUS_BITS + HANDLE_BITS;
   localparam int HV_BIT = CNT_LO + CNT_BITS;

   logic [STATUS_BITS-1:0] rsp_status;
   logic [HANDLE_BITS-1:0] rsp_handle;
   logic [CNT_BITS-1:0]    rsp_count;
   logic                   rsp_head_valid;

   assign rsp_status     = rsp_tdata[STATUS_BITS-1:0];
   assign rsp_handle     = rsp_tdata[STATUS_BITS +: HANDLE_BITS];
   assign rsp_count      = rsp_tdata[CNT_LO +: CNT_BITS];
   assign rsp_head_valid = rsp_tdata[HV_BIT];

   // A response that is not taken stays on the bus unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // Every accepted request word yields a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no response after an accepted request");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_head_valid == (rsp_count != '0)) &&
                     (rsp_count <= CNT_BITS'(DEPTH)))
      else $error("head flag or count out of line");

   a_refused_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != ST_DONE) |-> rsp_handle == '0)
      else $error("refused action returned a handle");

   // A word accepted while a response is shown moves the count by at most one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid |=>
         (rsp_count == $past(rsp_count)) ||
         (rsp_count == $past(rsp_count) + 1'b1) ||
         (rsp_count == $past(rsp_count) - 1'b1))
      else $error("count moved by more than one");

endmodule

bind sorted_priority_queue spq_checker #(
   .DEPTH    (DEPTH),
   .CNT_BITS (CNT_BITS),
   .RSP_BITS (RSP_BITS)
) u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
